// ===== rtl/acm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio channel mixer package
// Shared widths, register indexes and the controller to datapath interface.
// ----------------------------------------------------------------------------
package acm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int VOL_W    = 8;
   localparam int MASTER_W = 9;
   localparam int SUM_W    = 32;
   localparam int MUL_A_W  = 32;
   localparam int MUL_B_W  = 10;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_VOLUME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_STEREO   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_STEREO    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_8BIT      = 2'd3;

   localparam logic [MASTER_W-1:0] MASTER_VOLUME_RESET = 9'd179;

   typedef enum logic [1:0] {
      MUL_LEFT,
      MUL_RIGHT,
      MUL_FIN_LEFT,
      MUL_FIN_RIGHT
   } mul_sel_type;

   typedef struct packed {
      logic        load_item;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_left;
      logic        acc_right;
      logic        clamp_left;
      logic        clamp_right;
      logic        load_out;
   } acm_cmd_type;

   typedef struct packed {
      logic is_last;
      logic out_free;
   } acm_status_type;

endpackage

// ===== rtl/acm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio channel mixer controller
// Sequences the shared multiplier through mixing and the frame finish.
// ----------------------------------------------------------------------------
module acm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  acm_pkg::acm_status_type status,
   output acm_pkg::acm_cmd_type   cmd
);
   import acm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_L,
      ST_MUL_R,
      ST_ACC_R,
      ST_FIN_L,
      ST_FIN_R,
      ST_FIN_W,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mul_sel = MUL_LEFT;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
            if (req_valid) begin
               state_in = ST_MUL_L;
            end
         end
         ST_MUL_L: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LEFT;
            state_in    = ST_MUL_R;
         end
         ST_MUL_R: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_RIGHT;
            cmd.acc_left = 1'b1;
            state_in     = ST_ACC_R;
         end
         ST_ACC_R: begin
            cmd.acc_right = 1'b1;
            state_in      = status.is_last ? ST_FIN_L : ST_IDLE;
         end
         ST_FIN_L: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_FIN_LEFT;
            state_in    = ST_FIN_R;
         end
         ST_FIN_R: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_sel    = MUL_FIN_RIGHT;
            cmd.clamp_left = 1'b1;
            state_in       = ST_FIN_W;
         end
         ST_FIN_W: begin
            cmd.clamp_right = 1'b1;
            state_in        = ST_OUT;
         end
         ST_OUT: begin
            cmd.load_out = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/acm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio channel mixer datapath
// Item and configuration registers, shared multiplier, sums and output stage.
// ----------------------------------------------------------------------------
module acm_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  acm_pkg::acm_cmd_type                  cmd,
   output acm_pkg::acm_status_type               status,
   input  logic signed [acm_pkg::SAMPLE_W-1:0]   req_source_sample,
   input  logic                                  req_source_is_8bit,
   input  logic [acm_pkg::VOL_W-1:0]             req_left_volume,
   input  logic [acm_pkg::VOL_W-1:0]             req_right_volume,
   input  logic                                  req_last_channel,
   input  logic                                  csr_valid,
   input  logic [acm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [acm_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [acm_pkg::SAMPLE_W-1:0]   rsp_left_out,
   output logic signed [acm_pkg::SAMPLE_W-1:0]   rsp_right_out
);
   import acm_pkg::*;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       is8_ff;
   logic [VOL_W-1:0]           lvol_ff, rvol_ff;
   logic                       last_ff;

   logic [MASTER_W-1:0] master_ff;
   logic                swap_ff, stereo_ff, out8_ff;

   logic signed [SUM_W-1:0]  left_sum_ff, right_sum_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SAMPLE_W-1:0] lclamp_ff, rclamp_ff;

   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_left_ff, out_right_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [SAMPLE_W-1:0] samp_ext;
   logic [VOL_W-1:0]          lvol_eff, rvol_eff;
   logic signed [SUM_W-1:0]   addend;
   logic signed [SAMPLE_W-1:0] clamped;
   logic signed [SAMPLE_W-1:0] fin_left, fin_right;

   function automatic logic signed [SAMPLE_W-1:0] clamp16(
      input logic signed [PROD_W-1:0] p
   );
      logic signed [PROD_W-9:0] v;
      begin
         v = p[PROD_W-1:8];
         if (v > $signed((PROD_W-8)'(32767))) begin
            clamp16 = 16'sh7fff;
         end else if (v < -$signed((PROD_W-8)'(32768))) begin
            clamp16 = 16'sh8000;
         end else begin
            clamp16 = v[SAMPLE_W-1:0];
         end
      end
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] fmt(
      input logic signed [SAMPLE_W-1:0] v,
      input logic                       as8
   );
      begin
         fmt = as8 ? {8'd0, ~v[15], v[14:8]} : v;
      end
   endfunction

   always_comb begin
      samp_ext = is8_ff ? SAMPLE_W'(signed'(sample_ff[7:0])) : sample_ff;
      lvol_eff = is8_ff ? {lvol_ff[7:3], 3'd0} : lvol_ff;
      rvol_eff = is8_ff ? {rvol_ff[7:3], 3'd0} : rvol_ff;
      case (cmd.mul_sel)
         MUL_LEFT: begin
            mul_a = MUL_A_W'(samp_ext);
            mul_b = signed'({2'b00, lvol_eff});
         end
         MUL_RIGHT: begin
            mul_a = MUL_A_W'(samp_ext);
            mul_b = signed'({2'b00, rvol_eff});
         end
         MUL_FIN_LEFT: begin
            mul_a = left_sum_ff;
            mul_b = signed'({1'b0, master_ff});
         end
         MUL_FIN_RIGHT: begin
            mul_a = right_sum_ff;
            mul_b = signed'({1'b0, master_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      addend  = is8_ff ? prod_ff[SUM_W-1:0] : prod_ff[SUM_W+7:8];
      clamped = clamp16(prod_ff);
      if (!stereo_ff) begin
         fin_left  = fmt(lclamp_ff, out8_ff);
         fin_right = '0;
      end else if (swap_ff && !out8_ff) begin
         fin_left  = rclamp_ff;
         fin_right = lclamp_ff;
      end else begin
         fin_left  = fmt(lclamp_ff, out8_ff);
         fin_right = fmt(rclamp_ff, out8_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         sample_ff <= req_source_sample;
         is8_ff    <= req_source_is_8bit;
         lvol_ff   <= req_left_volume;
         rvol_ff   <= req_right_volume;
         last_ff   <= req_last_channel;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.clamp_left) begin
         lclamp_ff <= clamped;
      end
      if (cmd.clamp_right) begin
         rclamp_ff <= clamped;
      end
      if (cmd.load_out) begin
         out_left_ff  <= fin_left;
         out_right_ff <= fin_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff    <= MASTER_VOLUME_RESET;
         swap_ff      <= 1'b0;
         stereo_ff    <= 1'b1;
         out8_ff      <= 1'b0;
         left_sum_ff  <= '0;
         right_sum_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_MASTER_VOLUME: master_ff <= csr_wdata;
               CSR_SWAP_STEREO:   swap_ff   <= csr_wdata[0];
               CSR_OUT_STEREO:    stereo_ff <= csr_wdata[0];
               CSR_OUT_8BIT:      out8_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (cmd.load_out) begin
            left_sum_ff  <= '0;
            right_sum_ff <= '0;
         end else begin
            if (cmd.acc_left) begin
               left_sum_ff <= left_sum_ff + addend;
            end
            if (cmd.acc_right) begin
               right_sum_ff <= right_sum_ff + addend;
            end
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign status.is_last  = last_ff;
   assign status.out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign rsp_left_out    = out_left_ff;
   assign rsp_right_out   = out_right_ff;

endmodule

// ===== rtl/audio_channel_mixer.sv =====
`timescale 1ns / 1ps
// Items are taken one at a time: each runs ST_MUL_L, ST_MUL_R and ST_ACC_R,
// the shared multiplier taking the left and right products in turn; a
// last-channel item then closes the frame through ST_FIN_L to ST_OUT.
// Reset: synchronous, clears the sums and output valid and restores the
// register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// Audio channel mixer
// Accumulates per-channel stereo contributions and emits one mixed sample
// per frame with master gain, clamping and output formatting.
// ----------------------------------------------------------------------------
module audio_channel_mixer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [acm_pkg::SAMPLE_W-1:0] req_source_sample,
   input  logic                                req_source_is_8bit,
   input  logic [acm_pkg::VOL_W-1:0]           req_left_volume,
   input  logic [acm_pkg::VOL_W-1:0]           req_right_volume,
   input  logic                                req_last_channel,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [acm_pkg::SAMPLE_W-1:0] rsp_left_out,
   output logic signed [acm_pkg::SAMPLE_W-1:0] rsp_right_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [acm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [acm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import acm_pkg::*;

   acm_cmd_type    cmd;
   acm_status_type status;

   assign csr_ready = 1'b1;

   acm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   acm_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_source_sample  (req_source_sample),
      .req_source_is_8bit (req_source_is_8bit),
      .req_left_volume    (req_left_volume),
      .req_right_volume   (req_right_volume),
      .req_last_channel   (req_last_channel),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_left_out       (rsp_left_out),
      .rsp_right_out      (rsp_right_out)
   );

endmodule

// ===== rtl/acm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio channel mixer checker
// Port-level properties of the mixer, bound to the top level.
// ----------------------------------------------------------------------------
module acm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [acm_pkg::SAMPLE_W-1:0] rsp_left_out,
   input logic signed [acm_pkg::SAMPLE_W-1:0] rsp_right_out
);

   // A reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The block works on one item at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready right after a transfer");

   // A new result is only produced while the input side is busy.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a frame in progress");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out)))
      else $error("stalled result changed");

endmodule

bind audio_channel_mixer acm_checker u_acm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_left_out  (rsp_left_out),
   .rsp_right_out (rsp_right_out)
);
